// ===== src/pulse_start_serial_byte_receiver_top_macros.svh =====
// assertion macros for the pulse-start serial byte receiver checker
// used by the checker file only, no other dependencies
`ifndef PULSE_START_SERIAL_BYTE_RECEIVER_TOP_MACROS_SVH
`define PULSE_START_SERIAL_BYTE_RECEIVER_TOP_MACROS_SVH

// clocked assertion, switched off while reset is held
`define PSBR_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PSBR_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/psbr_pkg.sv =====
// shared types and constants of the pulse-start serial byte receiver
// no dependencies
`default_nettype none

package psbr_pkg;

    // fixed field widths
    localparam int DATA_BITS    = 8;
    localparam int COUNTER_BITS = 16;
    localparam int CFG_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int TICK_W       = 8;
    localparam int BIT_IDX_W    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 8;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(DATA_BITS - 1);

    // register reset values
    localparam logic [CFG_W-1:0]  RST_MIN_PULSE    = CFG_W'(60);
    localparam logic [CFG_W-1:0]  RST_MAX_PULSE    = CFG_W'(70);
    localparam logic [TICK_W-1:0] RST_FIRST_SAMPLE = TICK_W'(15);
    localparam logic [TICK_W-1:0] RST_BIT_PERIOD   = TICK_W'(45);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PULSE    = 2'd0,
        REG_MAX_PULSE    = 2'd1,
        REG_FIRST_SAMPLE = 2'd2,
        REG_BIT_PERIOD   = 2'd3
    } t_cfg_reg;

    // configuration seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0]  min_pulse;
        logic [CFG_W-1:0]  max_pulse;
        logic [TICK_W-1:0] first_sample;
        logic [TICK_W-1:0] bit_period;
    } t_cfg;

    // registered line sample handed to the core
    typedef struct packed {
        logic valid;
        logic level;
    } t_sample;

endpackage

`default_nettype wire

// ===== src/psbr_cfg.sv =====
// configuration registers of the pulse-start serial byte receiver
// depends on psbr_pkg
`default_nettype none

module psbr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [psbr_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [psbr_pkg::CFG_W-1:0]     i_data,
    output psbr_pkg::t_cfg                      o_cfg
);

    psbr_pkg::t_cfg r_cfg;
    psbr_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (psbr_pkg::t_cfg_reg'(i_index))
                psbr_pkg::REG_MIN_PULSE:    n_cfg.min_pulse    = i_data;
                psbr_pkg::REG_MAX_PULSE:    n_cfg.max_pulse    = i_data;
                psbr_pkg::REG_FIRST_SAMPLE: n_cfg.first_sample =
                    i_data[psbr_pkg::TICK_W-1:0];
                psbr_pkg::REG_BIT_PERIOD:   n_cfg.bit_period   =
                    i_data[psbr_pkg::TICK_W-1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse    <= psbr_pkg::RST_MIN_PULSE;
            r_cfg.max_pulse    <= psbr_pkg::RST_MAX_PULSE;
            r_cfg.first_sample <= psbr_pkg::RST_FIRST_SAMPLE;
            r_cfg.bit_period   <= psbr_pkg::RST_BIT_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/psbr_in_stage.sv =====
// input register stage: holds one line sample for the core
// depends on psbr_pkg
`default_nettype none

module psbr_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_level,
    input  wire logic  i_advance,
    output logic       o_ready,
    output psbr_pkg::t_sample o_sample
);

    logic r_valid;
    logic r_level;

    // room when empty or when the held sample moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // sample payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_level <= i_level;
        end
    end

    assign o_sample.valid = r_valid;
    assign o_sample.level = r_level;

endmodule

`default_nettype wire

// ===== src/psbr_core.sv =====
// receiver state update and result register
// depends on psbr_pkg
`default_nettype none

module psbr_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire psbr_pkg::t_sample i_sample,
    input  wire psbr_pkg::t_cfg    i_cfg,
    input  wire logic  i_out_ready,
    output logic       o_advance,
    output logic       o_valid,
    output logic [psbr_pkg::BYTE_W-1:0] o_byte
);

    logic                                r_last_level;
    logic [psbr_pkg::COUNTER_BITS-1:0]   r_counter;
    logic                                r_receiving;
    logic [psbr_pkg::TICK_W-1:0]         r_countdown;
    logic [psbr_pkg::BIT_IDX_W-1:0]      r_bit_idx;
    logic [psbr_pkg::BYTE_W-1:0]         r_shift;
    logic                                r_out_valid;
    logic [psbr_pkg::BYTE_W-1:0]         r_out_byte;

    logic                                n_last_level;
    logic [psbr_pkg::COUNTER_BITS-1:0]   n_counter;
    logic                                n_receiving;
    logic [psbr_pkg::TICK_W-1:0]         n_countdown;
    logic [psbr_pkg::BIT_IDX_W-1:0]      n_bit_idx;
    logic [psbr_pkg::BYTE_W-1:0]         n_shift;
    logic                                n_emit;

    logic [psbr_pkg::COUNTER_BITS-1:0]   w_count_inc;
    logic [psbr_pkg::CFG_W-1:0]          w_count_cmp;
    logic                                w_in_window;
    logic                                w_level;

    // a sample moves on when the result register is free or being drained
    assign o_advance = i_sample.valid && (!r_out_valid || i_out_ready);

    assign w_level     = i_sample.level;
    assign w_count_inc = psbr_pkg::COUNTER_BITS'(r_counter + 1'b1);
    assign w_count_cmp = psbr_pkg::CFG_W'(w_count_inc);
    assign w_in_window = (w_count_cmp >= i_cfg.min_pulse) &&
                         (w_count_cmp <= i_cfg.max_pulse);

    // next state for one line sample
    always_comb begin
        n_last_level = r_last_level;
        n_counter    = r_counter;
        n_receiving  = r_receiving;
        n_countdown  = r_countdown;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_emit       = 1'b0;
        if (o_advance) begin
            if (r_receiving) begin
                // sampling data bits, line edges ignored
                n_counter = w_count_inc;
                if (r_countdown <= psbr_pkg::TICK_W'(1)) begin
                    n_shift = r_shift |
                              (psbr_pkg::BYTE_W'(w_level) << r_bit_idx);
                    if (r_bit_idx >= psbr_pkg::LAST_BIT_IDX) begin
                        n_emit       = 1'b1;
                        n_receiving  = 1'b0;
                        n_last_level = 1'b1;
                        n_countdown  = '0;
                        n_bit_idx    = '0;
                    end else begin
                        n_bit_idx   = psbr_pkg::BIT_IDX_W'(r_bit_idx + 1'b1);
                        n_countdown = i_cfg.bit_period;
                    end
                end else begin
                    n_countdown = psbr_pkg::TICK_W'(r_countdown - 1'b1);
                end
            end else begin
                // idle: measure the low pulse, qualify on the rising edge
                if (r_last_level && !w_level) begin
                    n_counter = '0;
                end else begin
                    n_counter = w_count_inc;
                    if (!r_last_level && w_level && w_in_window) begin
                        n_receiving = 1'b1;
                        n_countdown = i_cfg.first_sample;
                        n_bit_idx   = '0;
                        n_shift     = '0;
                    end
                end
                n_last_level = w_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_counter    <= '0;
            r_receiving  <= 1'b0;
            r_countdown  <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_last_level <= n_last_level;
            r_counter    <= n_counter;
            r_receiving  <= n_receiving;
            r_countdown  <= n_countdown;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            if (o_advance) begin
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_advance && n_emit) begin
            r_out_byte <= n_shift;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;

endmodule

`default_nettype wire

// ===== src/pulse_start_serial_byte_receiver_top.sv =====
// Pulse-start serial byte receiver. Takes one line sample per clock on the
// slave stream, one request per tick, while tready is high; a new sample is
// accepted every cycle unless stalled, and each sample passes through an
// input register and a single state update into the result register, from
// which a received byte is presented on the master side.
// Input requests stall only while a finished byte waits in the result
// register and the master side holds tready low.
// Configuration writes are registered and must be made while idle.
// top level: wires the config registers, input stage and receiver core
// depends on psbr_pkg, psbr_cfg, psbr_in_stage, psbr_core
`default_nettype none

module pulse_start_serial_byte_receiver_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave stream, tdata: [0] line_level, [7:1] zero
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [psbr_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // master stream, tdata: [7:0] received_byte
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [psbr_pkg::BYTE_W-1:0]         o_m_axis_tdata,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [psbr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [psbr_pkg::CFG_W-1:0]     i_cfg_data
);

    psbr_pkg::t_cfg    w_cfg;
    psbr_pkg::t_sample w_sample;
    logic              w_advance;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    psbr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // input register
    psbr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_level   (i_s_axis_tdata[0]),
        .i_advance (w_advance),
        .o_ready   (o_s_axis_tready),
        .o_sample  (w_sample)
    );

    // state update and result register
    psbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_sample),
        .i_cfg       (w_cfg),
        .i_out_ready (i_m_axis_tready),
        .o_advance   (w_advance),
        .o_valid     (o_m_axis_tvalid),
        .o_byte      (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== src/psbr_checker.sv =====
// port-level checks for the pulse-start serial byte receiver
// depends on psbr_pkg and pulse_start_serial_byte_receiver_top_macros.svh
`default_nettype none
`include "pulse_start_serial_byte_receiver_top_macros.svh"

module psbr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [psbr_pkg::BYTE_W-1:0]     o_m_axis_tdata
);

    // reset empties the result register
    `PSBR_ASSERT(a_rst_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // a held byte stays put until taken
    `PSBR_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result dropped or changed while stalled")

    // input only stalls behind a waiting byte
    `PSBR_ASSERT_RST(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty result register")

    // a new byte comes from a sample accepted earlier on the slave stream
    `PSBR_ASSERT_RST(a_out_from_input, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2), "result without a preceding sample")

endmodule

bind pulse_start_serial_byte_receiver_top psbr_checker u_psbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
